[hw/rtl/card_id_frame_serializer_macros.svh]
// assertion macros shared by the card id frame serializer modules
// expects signals clk and rst_n in the scope where a macro is used
`ifndef CARD_ID_FRAME_SERIALIZER_MACROS_SVH
`define CARD_ID_FRAME_SERIALIZER_MACROS_SVH

// same-cycle implication
`define CIDFS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cidfs same-cycle check failed");

// next-cycle implication
`define CIDFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cidfs next-cycle check failed");

`endif

[hw/rtl/cidfs_pkg.sv]
// shared types and constants for the card id frame serializer
// no dependencies
`timescale 1ns / 1ps

package cidfs_pkg;

    localparam int ID_BYTES      = 8;
    localparam int PREAMBLE_BITS = 8;

    localparam int CHAR_W = 7;
    localparam logic [CHAR_W-1:0] HDR_STX  = 7'h02;
    localparam logic [CHAR_W-1:0] HDR_TWO  = 7'h32;
    localparam logic [CHAR_W-1:0] HDR_ZERO = 7'h30;

    localparam int BYTE_CNT_W = (ID_BYTES > 1) ? $clog2(ID_BYTES) : 1;
    localparam int STEP_W     = ($clog2(PREAMBLE_BITS) > 4) ? $clog2(PREAMBLE_BITS) : 4;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // one classified id byte, ready for the serializer
    typedef struct packed {
        logic              first;
        logic              last;
        logic [CHAR_W-1:0] data;
        logic [CHAR_W-1:0] csum;
    } cidfs_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } cidfs_qstat_t;

endpackage

[hw/rtl/cidfs_queue.sv]
// two-entry command queue between the byte front end and the bit serializer
// depends on cidfs_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "card_id_frame_serializer_macros.svh"

module cidfs_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  cidfs_pkg::cidfs_cmd_t push_cmd,
    input  logic                  pop,
    output cidfs_pkg::cidfs_cmd_t head_cmd,
    output cidfs_pkg::cidfs_qstat_t stat
);
    import cidfs_pkg::*;

    cidfs_cmd_t           mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;

    assign stat.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `CIDFS_ASSERT_NOW(a_q_no_overflow, push, !stat.full)
    `CIDFS_ASSERT_NOW(a_q_no_underflow, pop, !stat.empty)
    `CIDFS_ASSERT_NOW(a_q_count_range, 1'b1, count_reg <= Q_CNT_W'(Q_DEPTH))

endmodule

[hw/rtl/cidfs_front.sv]
// front end: takes id bytes, tracks frame position and the running xor
// depends on cidfs_pkg
`timescale 1ns / 1ps

module cidfs_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    id_valid,
    output logic                    id_ready,
    input  logic [7:0]              id_byte,
    input  cidfs_pkg::cidfs_qstat_t q_stat,
    output logic                    push,
    output cidfs_pkg::cidfs_cmd_t   push_cmd
);
    import cidfs_pkg::*;

    logic [BYTE_CNT_W-1:0] cnt_reg;
    logic [BYTE_CNT_W-1:0] cnt_next;
    logic [CHAR_W-1:0]     xor_reg;
    logic [CHAR_W-1:0]     xor_next;
    logic [CHAR_W-1:0]     xor_now;
    logic                  is_last;

    assign id_ready = !q_stat.full;
    assign push     = id_valid && id_ready;

    // bit 7 never reaches the line, so only the low seven xor bits are kept
    assign xor_now = xor_reg ^ id_byte[CHAR_W-1:0];
    assign is_last = (cnt_reg == BYTE_CNT_W'(ID_BYTES - 1));

    always_comb
    begin
        push_cmd.first = (cnt_reg == '0);
        push_cmd.last  = is_last;
        push_cmd.data  = id_byte[CHAR_W-1:0];
        push_cmd.csum  = xor_now;
        cnt_next = cnt_reg;
        xor_next = xor_reg;
        if (push)
        begin
            if (is_last)
            begin
                cnt_next = '0;
                xor_next = '0;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
                xor_next = xor_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            xor_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            xor_reg <= xor_next;
        end
    end

endmodule

[hw/rtl/cidfs_back.sv]
// back end: walks preamble, header, data, checksum chars one bit a cycle unless stalled
// depends on cidfs_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "card_id_frame_serializer_macros.svh"

module cidfs_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cidfs_pkg::cidfs_qstat_t q_stat,
    input  cidfs_pkg::cidfs_cmd_t   head_cmd,
    output logic                    pop,
    output logic                    bit_valid,
    input  logic                    bit_ready,
    output logic                    line_bit,
    output logic                    frame_end
);
    import cidfs_pkg::*;

    localparam logic [2:0] PH_PRE  = 3'd0;
    localparam logic [2:0] PH_HDR0 = 3'd1;
    localparam logic [2:0] PH_HDR1 = 3'd2;
    localparam logic [2:0] PH_HDR2 = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_CSUM = 3'd5;

    localparam logic [STEP_W-1:0] STEP_START  = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_PARITY = STEP_W'(8);
    localparam logic [STEP_W-1:0] STEP_STOP   = STEP_W'(9);
    localparam logic [STEP_W-1:0] PRE_LAST    = STEP_W'(PREAMBLE_BITS - 1);

    cidfs_cmd_t        cmd_reg;
    cidfs_cmd_t        cmd_next;
    logic              busy_reg;
    logic              busy_next;
    logic [2:0]        phase_reg;
    logic [2:0]        phase_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              bit_valid_reg;
    logic              bit_valid_next;
    logic              line_bit_reg;
    logic              frame_end_reg;

    logic [CHAR_W-1:0] cur_char;
    logic [2:0]        data_idx;
    logic              cur_bit;
    logic              char_done;
    logic              item_done;
    logic              advance;
    logic              load;

    assign bit_valid = bit_valid_reg;
    assign line_bit  = line_bit_reg;
    assign frame_end = frame_end_reg;

    assign advance   = busy_reg && (!bit_valid_reg || bit_ready);
    assign char_done = (step_reg == STEP_STOP);
    assign item_done = char_done &&
                       ((phase_reg == PH_CSUM) || ((phase_reg == PH_DATA) && !cmd_reg.last));
    // take the next word while idle, or on the cycle the current one sends its final bit
    assign load = !q_stat.empty && (!busy_reg || (advance && item_done));
    assign pop  = load;
    assign data_idx = 3'(step_reg - STEP_W'(1));

    always_comb
    begin
        unique case (phase_reg)
            PH_HDR0: cur_char = HDR_STX;
            PH_HDR1: cur_char = HDR_TWO;
            PH_HDR2: cur_char = HDR_ZERO;
            PH_DATA: cur_char = cmd_reg.data;
            PH_CSUM: cur_char = cmd_reg.csum;
            default: cur_char = '0;
        endcase

        priority if (phase_reg == PH_PRE)
        begin
            cur_bit = 1'b1;
        end
        else if (step_reg == STEP_START)
        begin
            cur_bit = 1'b0;
        end
        else if (step_reg == STEP_PARITY)
        begin
            // odd parity over the seven data bits
            cur_bit = ~^cur_char;
        end
        else if (step_reg == STEP_STOP)
        begin
            cur_bit = 1'b1;
        end
        else
        begin
            cur_bit = cur_char[data_idx];
        end
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        busy_next      = busy_reg;
        phase_next     = phase_reg;
        step_next      = step_reg;
        bit_valid_next = bit_valid_reg;

        if (advance)
        begin
            bit_valid_next = 1'b1;
        end
        else if (bit_ready)
        begin
            bit_valid_next = 1'b0;
        end

        if (load)
        begin
            cmd_next   = head_cmd;
            busy_next  = 1'b1;
            phase_next = head_cmd.first ? PH_PRE : PH_DATA;
            step_next  = '0;
        end
        else if (advance)
        begin
            priority if (item_done)
            begin
                busy_next = 1'b0;
            end
            else if (phase_reg == PH_PRE)
            begin
                if (step_reg == PRE_LAST)
                begin
                    phase_next = PH_HDR0;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            else if (char_done)
            begin
                step_next = '0;
                unique case (phase_reg)
                    PH_HDR0: phase_next = PH_HDR1;
                    PH_HDR1: phase_next = PH_HDR2;
                    PH_HDR2: phase_next = PH_DATA;
                    PH_DATA: phase_next = PH_CSUM;
                    default: phase_next = PH_PRE;
                endcase
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= PH_PRE;
            step_reg      <= '0;
            bit_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            bit_valid_reg <= bit_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (advance)
        begin
            line_bit_reg  <= cur_bit;
            frame_end_reg <= (phase_reg == PH_CSUM) && char_done;
        end
    end

    `CIDFS_ASSERT_NOW(a_frame_end_on_stop, bit_valid_reg && frame_end_reg, line_bit_reg)
    `CIDFS_ASSERT_NOW(a_csum_only_last, busy_reg && (phase_reg == PH_CSUM), cmd_reg.last)
    `CIDFS_ASSERT_NOW(a_step_in_char, busy_reg && (phase_reg != PH_PRE), step_reg <= STEP_STOP)
    `CIDFS_ASSERT_NEXT(a_advance_fills, advance, bit_valid_reg)

endmodule

[hw/rtl/card_id_frame_serializer.sv]
// top level of the card id frame serializer: front end, command queue, bit serializer
// depends on cidfs_pkg, cidfs_front, cidfs_queue and cidfs_back
`timescale 1ns / 1ps
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------
//  id in    | id_valid / id_ready   | id_byte[7:0]
//  bit out  | bit_valid / bit_ready | line_bit, frame_end
//
// one line bit leaves per cycle while busy with bit_ready high; a byte sends its data character,
// the first byte of a frame also preamble and three header characters, the last byte the checksum.
// a two-word queue lets the front take up to two bytes ahead of the serializer.
// rst_n clears the frame position, running xor, queue and output valid at once.
// a low bit_ready holds a valid output bit and stops the serializer; id_ready drops
// only when the queue is full.

module card_id_frame_serializer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       id_valid,
    output logic       id_ready,
    input  logic [7:0] id_byte,
    output logic       bit_valid,
    input  logic       bit_ready,
    output logic       line_bit,
    output logic       frame_end
);
    import cidfs_pkg::*;

    cidfs_qstat_t q_stat;
    cidfs_cmd_t   push_cmd;
    cidfs_cmd_t   head_cmd;
    logic         push;
    logic         pop;

    cidfs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .id_valid (id_valid),
        .id_ready (id_ready),
        .id_byte  (id_byte),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    cidfs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .stat     (q_stat)
    );

    cidfs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .head_cmd  (head_cmd),
        .pop       (pop),
        .bit_valid (bit_valid),
        .bit_ready (bit_ready),
        .line_bit  (line_bit),
        .frame_end (frame_end)
    );

endmodule
